// ===== src/first_match_type_classifier_counter_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the first-match classifier
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_TYPE_CLASSIFIER_COUNTER_TOP_ASSERT_SVH
`define FIRST_MATCH_TYPE_CLASSIFIER_COUNTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FMTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fmtc assertion failed");
// next-cycle implication
`define FMTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fmtc assertion failed");
`else
`define FMTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FMTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/fmtc_pkg.sv =====
// ----------------------------------------------------------------------------
// fmtc_pkg
// Types and constants shared by the first-match classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fmtc_pkg;

  localparam int unsigned MODE_W        = 2;
  localparam int unsigned TYPE_W        = 32;
  localparam int unsigned IDX_FIELD_W   = 3;
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned COUNT_W       = 32;
  localparam int unsigned NUM_RULES_DEF = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLASSIFY = 2'd0,
    MODE_LOAD     = 2'd1,
    MODE_READ     = 2'd2
  } mode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNUSED      = 3'd0,
    KIND_ANY         = 3'd1,
    KIND_SRC         = 3'd2,
    KIND_DST         = 3'd3,
    KIND_SRC_AND_DST = 3'd4,
    KIND_SRC_OR_DST  = 3'd5,
    KIND_NEXT        = 3'd6
  } kind_e;

  // per-lane strobes from the top level
  typedef struct packed {
    logic load;
    logic incr;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== src/fmtc_rule_lane.sv =====
// ----------------------------------------------------------------------------
// fmtc_rule_lane
// One rule slot: stored kind and operands, match compare, hit counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmtc_rule_lane (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire fmtc_pkg::lane_ctrl_t           ctrl_i,
  input  wire logic [fmtc_pkg::KIND_W-1:0]    kind_i,
  input  wire logic [fmtc_pkg::TYPE_W-1:0]    src_type_i,
  input  wire logic [fmtc_pkg::TYPE_W-1:0]    dst_type_i,
  input  wire logic [fmtc_pkg::TYPE_W-1:0]    next_type_i,
  output logic                                hit_o,
  output logic [fmtc_pkg::COUNT_W-1:0]        count_o
);
  import fmtc_pkg::*;

  logic [KIND_W-1:0]  kind_q;
  logic [TYPE_W-1:0]  src_q, dst_q, next_q;
  logic [COUNT_W-1:0] count_q;
  logic               src_eq, dst_eq, next_eq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_UNUSED;
      count_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        kind_q <= kind_i;
      end
      if (ctrl_i.incr) begin
        count_q <= count_q + COUNT_W'(1);
      end
    end
  end

  // operand compares only take effect once the slot has a real kind
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      src_q  <= src_type_i;
      dst_q  <= dst_type_i;
      next_q <= next_type_i;
    end
  end

  assign src_eq  = (src_type_i == src_q);
  assign dst_eq  = (dst_type_i == dst_q);
  assign next_eq = (next_type_i == next_q);

  always_comb begin
    case (kind_e'(kind_q))
      KIND_ANY:         hit_o = 1'b1;
      KIND_SRC:         hit_o = src_eq;
      KIND_DST:         hit_o = dst_eq;
      KIND_SRC_AND_DST: hit_o = src_eq && dst_eq;
      KIND_SRC_OR_DST:  hit_o = src_eq || dst_eq;
      KIND_NEXT:        hit_o = next_eq;
      default:          hit_o = 1'b0;
    endcase
  end

  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== src/first_match_type_classifier_counter_top.sv =====
// ----------------------------------------------------------------------------
// first_match_type_classifier_counter_top
// First-match rule classifier with a wrapping hit counter per rule.
// ----------------------------------------------------------------------------
//
//   channel   signals                            direction
//   -------   --------------------------------   ---------
//   in        in_valid_i / in_stall_o + fields   word into the block
//   out       out_valid_o / out_stall_i + fields word out of the block
//
// One word enters per cycle while in_stall_o is low; the input register loads
// on the accepting edge and the result register when the word fires, which a
// stall on out can delay.
// The compare / priority-encode / counter update logic is a single combinational
// path between the input register and the result register.
// Reset clears rule kinds (all slots unused) and all hit counters at once.
// A stall on out holds the result register and backs up to in_stall_o.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_match_type_classifier_counter_top #(
  parameter int unsigned NUM_RULES = fmtc_pkg::NUM_RULES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [fmtc_pkg::MODE_W-1:0]        mode_i,
  input  wire logic [fmtc_pkg::TYPE_W-1:0]        src_type_i,
  input  wire logic [fmtc_pkg::TYPE_W-1:0]        dst_type_i,
  input  wire logic [fmtc_pkg::TYPE_W-1:0]        next_type_i,
  input  wire logic [fmtc_pkg::IDX_FIELD_W-1:0]   entry_index_i,
  input  wire logic [fmtc_pkg::KIND_W-1:0]        entry_kind_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    matched_o,
  output logic [fmtc_pkg::IDX_FIELD_W-1:0]        match_index_o,
  output logic [fmtc_pkg::COUNT_W-1:0]            count_value_o
);
  import fmtc_pkg::*;

  // ---- input register ----
  logic                   pipe_valid_q, pipe_valid_d;
  logic [MODE_W-1:0]      mode_q;
  logic [TYPE_W-1:0]      src_q, dst_q, next_q;
  logic [IDX_FIELD_W-1:0] idx_q;
  logic [KIND_W-1:0]      kind_q;

  // ---- result register ----
  logic                   out_valid_q, out_valid_d;
  logic                   matched_q, matched_d;
  logic [IDX_FIELD_W-1:0] match_index_q, match_index_d;
  logic [COUNT_W-1:0]     count_q, count_d;

  logic in_accept;
  logic advance;
  logic fire;
  logic classify_fire;

  logic [NUM_RULES-1:0]   hit_vec;
  logic [NUM_RULES-1:0]   first_vec;
  logic [NUM_RULES-1:0]   read_sel;
  logic [NUM_RULES-1:0]   incr_vec;
  logic [COUNT_W-1:0]     lane_count [NUM_RULES];
  lane_ctrl_t             lane_ctrl  [NUM_RULES];

  logic                   any_hit;
  logic [IDX_FIELD_W-1:0] hit_index;
  logic [COUNT_W-1:0]     hit_count;
  logic [COUNT_W-1:0]     read_count;

  // result register frees up when empty or being drained
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = pipe_valid_q && advance;
  assign in_stall_o = pipe_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_accept) begin
      pipe_valid_d = 1'b1;
    end else if (advance) begin
      pipe_valid_d = 1'b0;
    end else begin
      pipe_valid_d = pipe_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pipe_valid_q <= pipe_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= mode_i;
      src_q  <= src_type_i;
      dst_q  <= dst_type_i;
      next_q <= next_type_i;
      idx_q  <= entry_index_i;
      kind_q <= entry_kind_i;
    end
  end

  // ---- rule lanes ----
  for (genvar i = 0; i < NUM_RULES; i++) begin : g_lane
    assign read_sel[i]       = (32'(idx_q) == 32'(i));
    assign lane_ctrl[i].load = fire && (mode_e'(mode_q) == MODE_LOAD) && read_sel[i];
    assign lane_ctrl[i].incr = incr_vec[i];

    fmtc_rule_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (lane_ctrl[i]),
      .kind_i      (kind_q),
      .src_type_i  (src_q),
      .dst_type_i  (dst_q),
      .next_type_i (next_q),
      .hit_o       (hit_vec[i]),
      .count_o     (lane_count[i])
    );
  end

  // priority pick: lowest-numbered hit wins
  always_comb begin
    logic found;
    found     = 1'b0;
    first_vec = '0;
    for (int i = 0; i < NUM_RULES; i++) begin
      first_vec[i] = hit_vec[i] && !found;
      found        = found || hit_vec[i];
    end
  end

  assign any_hit       = |hit_vec;
  assign classify_fire = fire && (mode_e'(mode_q) == MODE_CLASSIFY);
  assign incr_vec      = classify_fire ? first_vec : '0;

  // one-hot muxes for winner index/count and read-back count
  always_comb begin
    hit_index  = '0;
    hit_count  = '0;
    read_count = '0;
    for (int i = 0; i < NUM_RULES; i++) begin
      if (first_vec[i]) begin
        hit_index = hit_index | IDX_FIELD_W'(i);
        hit_count = hit_count | lane_count[i];
      end
      if (read_sel[i]) begin
        read_count = read_count | lane_count[i];
      end
    end
  end

  // ---- result formation ----
  always_comb begin
    matched_d     = 1'b0;
    match_index_d = '0;
    count_d       = '0;
    case (mode_e'(mode_q))
      MODE_CLASSIFY: begin
        if (any_hit) begin
          matched_d     = 1'b1;
          match_index_d = hit_index;
          count_d       = hit_count + COUNT_W'(1);
        end
      end
      MODE_READ: begin
        count_d = read_count;
      end
      default: begin
        count_d = '0;
      end
    endcase
  end

  always_comb begin
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      matched_q     <= matched_d;
      match_index_q <= match_index_d;
      count_q       <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign matched_o     = matched_q;
  assign match_index_o = match_index_q;
  assign count_value_o = count_q;

  // ---- checks ----
`include "first_match_type_classifier_counter_top_assert.svh"

  // at most one counter bumps per word, exactly one on a classify hit
  `FMTC_ASSERT_IMP(a_incr_onehot0, clk_i, rst_ni, 1'b1, $onehot0(incr_vec))
  `FMTC_ASSERT_IMP(a_hit_incr, clk_i, rst_ni, classify_fire && any_hit, $onehot(incr_vec))
  // a held result blocks the input stage from moving
  `FMTC_ASSERT_NXT(a_hold, clk_i, rst_ni, in_stall_o, pipe_valid_q && $stable(mode_q))

endmodule

`default_nettype wire
